// ===== design/akd_pkg.sv =====
// ----------------------------------------------------------------------------
// akd_pkg
// Shared types and codes for the analog keypad debouncer: key codes, request
// kinds, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package akd_pkg;

	typedef logic [2:0] key_t;

	localparam key_t KEY_LEFT   = 3'd0;
	localparam key_t KEY_UP     = 3'd1;
	localparam key_t KEY_DOWN   = 3'd2;
	localparam key_t KEY_RIGHT  = 3'd3;
	localparam key_t KEY_CENTER = 3'd4;
	localparam key_t KEY_NONE   = 3'd5;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_SAMPLE = 2'd0;
	localparam kind_t KIND_TICK   = 2'd1;
	localparam kind_t KIND_TAKE   = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	localparam int SAMPLE_W  = 10;
	localparam int DEBOUNCE_W = 8;
	localparam int DELAY_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [SAMPLE_W-1:0]   sample_t;
	typedef logic [DEBOUNCE_W-1:0] count_t;
	typedef logic [DELAY_W-1:0]    delay_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam cfg_idx_t REG_LIMIT_LEFT      = 3'd0;
	localparam cfg_idx_t REG_LIMIT_UP        = 3'd1;
	localparam cfg_idx_t REG_LIMIT_DOWN      = 3'd2;
	localparam cfg_idx_t REG_LIMIT_RIGHT     = 3'd3;
	localparam cfg_idx_t REG_LIMIT_CENTER    = 3'd4;
	localparam cfg_idx_t REG_DEBOUNCE_NEEDED = 3'd5;
	localparam cfg_idx_t REG_REPEAT_DELAY    = 3'd6;

	localparam sample_t RST_LIMIT_LEFT   = 10'd50;
	localparam sample_t RST_LIMIT_UP     = 10'd200;
	localparam sample_t RST_LIMIT_DOWN   = 10'd400;
	localparam sample_t RST_LIMIT_RIGHT  = 10'd600;
	localparam sample_t RST_LIMIT_CENTER = 10'd800;
	localparam count_t  RST_DEBOUNCE     = 8'd5;
	localparam delay_t  RST_REPEAT_DELAY = 32'd0;

	localparam count_t COUNT_MAX = 8'd255;

	typedef struct packed {
		sample_t limit_left;
		sample_t limit_up;
		sample_t limit_down;
		sample_t limit_right;
		sample_t limit_center;
		count_t  debounce_needed;
		delay_t  repeat_delay;
	} cfg_t;

	typedef struct packed {
		logic got_press;
		key_t pressed_button;
	} result_t;

endpackage

// ===== design/akd_decode.sv =====
// ----------------------------------------------------------------------------
// akd_decode
// Sort one ADC sample into a key code by five band limits checked in order.
// ----------------------------------------------------------------------------
module akd_decode (
	input  akd_pkg::sample_t adc_sample,
	input  akd_pkg::cfg_t    cfg,
	output akd_pkg::key_t    code
);
	import akd_pkg::*;

	// First limit the sample falls below wins; bands may be empty.
	always_comb begin
		if (adc_sample < cfg.limit_left) begin
			code = KEY_LEFT;
		end else if (adc_sample < cfg.limit_up) begin
			code = KEY_UP;
		end else if (adc_sample < cfg.limit_down) begin
			code = KEY_DOWN;
		end else if (adc_sample < cfg.limit_right) begin
			code = KEY_RIGHT;
		end else if (adc_sample < cfg.limit_center) begin
			code = KEY_CENTER;
		end else begin
			code = KEY_NONE;
		end
	end

endmodule

// ===== design/akd_state.sv =====
// ----------------------------------------------------------------------------
// akd_state
// Debounce state: previous code, repeat counter, pending flag, latched key
// and lockout countdown. Update on each advancing request; form its result.
// ----------------------------------------------------------------------------
module akd_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  akd_pkg::kind_t   kind,
	input  akd_pkg::key_t    code,
	input  akd_pkg::cfg_t    cfg,
	output akd_pkg::result_t result
);
	import akd_pkg::*;

	key_t   previous_code_q;
	count_t repeat_count_q;
	logic   press_pending_q;
	key_t   latched_key_q;
	delay_t lockout_left_q;

	key_t   previous_code_d;
	count_t repeat_count_d;
	logic   press_pending_d;
	key_t   latched_key_d;
	delay_t lockout_left_d;
	count_t count_inc;
	logic   blocked;

	assign blocked   = press_pending_q || (lockout_left_q != '0);
	assign count_inc = (repeat_count_q == COUNT_MAX) ? repeat_count_q
		: repeat_count_q + count_t'(1);

	always_comb begin
		previous_code_d = previous_code_q;
		repeat_count_d  = repeat_count_q;
		press_pending_d = press_pending_q;
		latched_key_d   = latched_key_q;
		lockout_left_d  = lockout_left_q;
		case (kind)
			KIND_SAMPLE: begin
				if (!blocked) begin
					if (code == previous_code_q) begin
						repeat_count_d = count_inc;
						if (code != KEY_NONE && count_inc > cfg.debounce_needed) begin
							latched_key_d   = code;
							press_pending_d = 1'b1;
							lockout_left_d  = cfg.repeat_delay;
						end
					end else begin
						repeat_count_d = '0;
					end
					previous_code_d = code;
				end
			end
			KIND_TICK: begin
				if (lockout_left_q != '0) begin
					lockout_left_d = lockout_left_q - delay_t'(1);
				end
			end
			KIND_TAKE: begin
				press_pending_d = 1'b0;
			end
			default: begin
				previous_code_d = KEY_NONE;
			end
		endcase
	end

	// Take reports the flag before clearing; all others report it after.
	always_comb begin
		result.got_press      = (kind == KIND_TAKE) ? press_pending_q : press_pending_d;
		result.pressed_button = latched_key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_code_q <= KEY_NONE;
			repeat_count_q  <= '0;
			press_pending_q <= 1'b0;
			latched_key_q   <= KEY_NONE;
			lockout_left_q  <= '0;
		end else if (advance) begin
			previous_code_q <= previous_code_d;
			repeat_count_q  <= repeat_count_d;
			press_pending_q <= press_pending_d;
			latched_key_q   <= latched_key_d;
			lockout_left_q  <= lockout_left_d;
		end
	end

	a_pending_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		press_pending_q |-> (latched_key_q != KEY_NONE))
		else $error("pending flag set without a latched key");

	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind == KIND_TAKE) |=> !press_pending_q)
		else $error("take did not clear the pending flag");

	a_blocked_sample_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind == KIND_SAMPLE && blocked) |=>
		($stable(previous_code_q) && $stable(repeat_count_q) && $stable(latched_key_q)))
		else $error("sample changed state during lockout");

endmodule

// ===== design/analog_keypad_debouncer.sv =====
// ----------------------------------------------------------------------------
// analog_keypad_debouncer
// Five-key resistor-ladder keypad decoder with debounce and repeat lockout.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid / in_stall | kind, adc_sample
//  out      | output    | out_valid/out_stall | got_press, pressed_button
//  cfg      | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
//  One result per request; the request waits in the input register, then
//  its result is loaded into the result register, where out_valid rises.
//  A new request is taken every cycle while the output is not stalled; the
//  single state update between the input register and the result register
//  sets that rate.
//  arst_n resets the debounce state, reloads register defaults, and empties both stages.
//  out_stall holds the result register; the input register then fills and
//  in_stall rises in the same cycle the held request cannot move on.
// ----------------------------------------------------------------------------
module analog_keypad_debouncer (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  akd_pkg::kind_t        kind,
	input  akd_pkg::sample_t      adc_sample,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  got_press,
	output akd_pkg::key_t         pressed_button,

	input  logic                  cfg_we,
	input  akd_pkg::cfg_idx_t     cfg_index,
	input  logic [akd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import akd_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	// Input register stage.
	logic    valid_s1;
	kind_t   kind_s1;
	sample_t sample_s1;

	// Result register.
	logic    out_valid_q;
	result_t result_q;

	key_t    code;
	result_t result;
	logic    advance;
	logic    load_s1;

	// Move the held request forward when the result register is free or
	// being drained this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_left      <= RST_LIMIT_LEFT;
			cfg_q.limit_up        <= RST_LIMIT_UP;
			cfg_q.limit_down      <= RST_LIMIT_DOWN;
			cfg_q.limit_right     <= RST_LIMIT_RIGHT;
			cfg_q.limit_center    <= RST_LIMIT_CENTER;
			cfg_q.debounce_needed <= RST_DEBOUNCE;
			cfg_q.repeat_delay    <= RST_REPEAT_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIMIT_LEFT:      cfg_q.limit_left      <= cfg_data[SAMPLE_W-1:0];
				REG_LIMIT_UP:        cfg_q.limit_up        <= cfg_data[SAMPLE_W-1:0];
				REG_LIMIT_DOWN:      cfg_q.limit_down      <= cfg_data[SAMPLE_W-1:0];
				REG_LIMIT_RIGHT:     cfg_q.limit_right     <= cfg_data[SAMPLE_W-1:0];
				REG_LIMIT_CENTER:    cfg_q.limit_center    <= cfg_data[SAMPLE_W-1:0];
				REG_DEBOUNCE_NEEDED: cfg_q.debounce_needed <= cfg_data[DEBOUNCE_W-1:0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay    <= cfg_data[DELAY_W-1:0];
				default: begin
					// Drop writes to unused indexes.
				end
			endcase
		end
	end

	// Input stage valid: fill on accept, empty when the request advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload: hold while stalled, capture on accept.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1   <= kind;
			sample_s1 <= adc_sample;
		end
	end

	akd_decode u_decode (
		.adc_sample (sample_s1),
		.cfg        (cfg_q),
		.code       (code)
	);

	akd_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.kind    (kind_s1),
		.code    (code),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result register: load on advance, clear once drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign got_press      = result_q.got_press;
	assign pressed_button = result_q.pressed_button;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked request");

	a_held_request_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(kind_s1) && $stable(sample_s1)))
		else $error("held request lost or changed");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(result_q)))
		else $error("stalled result changed");

endmodule

// ===== tb/sv/keypad_check_pkg.sv =====
// ----------------------------------------------------------------------------
// keypad_check_pkg
// Expected-report bookkeeping for the analog keypad debouncer: a shadow copy
// of the thresholds and the debounce state that predicts each report.
// ----------------------------------------------------------------------------
package keypad_check_pkg;

	import akd_pkg::*;

	class key_report_book;
		cfg_t    regs;
		key_t    prev_code;
		count_t  run_len;
		logic    pending;
		key_t    held_key;
		delay_t  lockout;
		result_t expected_reports[$];
		int      mismatches;
		int      reports_checked;
		int      presses_latched;

		function new();
			regs.limit_left      = RST_LIMIT_LEFT;
			regs.limit_up        = RST_LIMIT_UP;
			regs.limit_down      = RST_LIMIT_DOWN;
			regs.limit_right     = RST_LIMIT_RIGHT;
			regs.limit_center    = RST_LIMIT_CENTER;
			regs.debounce_needed = RST_DEBOUNCE;
			regs.repeat_delay    = RST_REPEAT_DELAY;
			prev_code       = KEY_NONE;
			run_len         = '0;
			pending         = 1'b0;
			held_key        = KEY_NONE;
			lockout         = '0;
			mismatches      = 0;
			reports_checked = 0;
			presses_latched = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LIMIT_LEFT:      regs.limit_left      = data[SAMPLE_W-1:0];
				REG_LIMIT_UP:        regs.limit_up        = data[SAMPLE_W-1:0];
				REG_LIMIT_DOWN:      regs.limit_down      = data[SAMPLE_W-1:0];
				REG_LIMIT_RIGHT:     regs.limit_right     = data[SAMPLE_W-1:0];
				REG_LIMIT_CENTER:    regs.limit_center    = data[SAMPLE_W-1:0];
				REG_DEBOUNCE_NEEDED: regs.debounce_needed = data[DEBOUNCE_W-1:0];
				REG_REPEAT_DELAY:    regs.repeat_delay    = data[DELAY_W-1:0];
				default: ;
			endcase
		endfunction

		// first threshold the level falls under wins
		function key_t classify(sample_t level);
			if (level < regs.limit_left)   return KEY_LEFT;
			if (level < regs.limit_up)     return KEY_UP;
			if (level < regs.limit_down)   return KEY_DOWN;
			if (level < regs.limit_right)  return KEY_RIGHT;
			if (level < regs.limit_center) return KEY_CENTER;
			return KEY_NONE;
		endfunction

		// Returns 0 for a sample the block drops while a key is held off.
		function bit note_request(kind_t k, sample_t level);
			result_t r;
			key_t    code;
			bit      counted;
			counted = 1'b1;
			case (k)
				KIND_SAMPLE: begin
					if (pending || lockout != '0) begin
						counted = 1'b0;
					end else begin
						code = classify(level);
						if (code == prev_code) begin
							if (run_len != COUNT_MAX)
								run_len++;
							if (code != KEY_NONE && run_len > regs.debounce_needed) begin
								held_key = code;
								pending  = 1'b1;
								lockout  = regs.repeat_delay;
								presses_latched++;
							end
						end else begin
							run_len = '0;
						end
						prev_code = code;
					end
					r.got_press = pending;
				end
				KIND_TICK: begin
					if (lockout != '0)
						lockout--;
					r.got_press = pending;
				end
				KIND_TAKE: begin
					r.got_press = pending;
					pending     = 1'b0;
				end
				KIND_CLEAR: begin
					prev_code   = KEY_NONE;
					r.got_press = pending;
				end
			endcase
			r.pressed_button = held_key;
			expected_reports.push_back(r);
			return counted;
		endfunction

		function void check_result(logic got, key_t key);
			result_t e;
			if (expected_reports.size() == 0) begin
				$error("report with none outstanding: got_press %0d, pressed_button %0d",
					got, key);
				mismatches++;
				return;
			end
			e = expected_reports.pop_front();
			reports_checked++;
			if (got !== e.got_press) begin
				$error("got_press: expected %0d, actual %0d", e.got_press, got);
				mismatches++;
			end
			if (key !== e.pressed_button) begin
				$error("pressed_button: expected %0d, actual %0d", e.pressed_button, key);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/analog_keypad_debouncer_test.sv =====
// ----------------------------------------------------------------------------
// analog_keypad_debouncer_test
// Drives keypad requests (samples, ticks, takes, clears) through several
// threshold and debounce settings with random gaps and output back-pressure,
// and checks every report against a shadow model of the debounce state.
// ----------------------------------------------------------------------------
module analog_keypad_debouncer_test;

	timeunit 1ns;
	timeprecision 1ps;

	import akd_pkg::*;
	import keypad_check_pkg::*;

	localparam int       WATCHDOG_CYCLES = 400000;
	localparam cfg_idx_t REG_UNUSED      = 3'd7;

	// Windows in which one side never idles.
	localparam int SEND_QUIET_FROM = 600;
	localparam int SEND_QUIET_TO   = 900;
	localparam int RECV_QUIET_FROM = 1200;
	localparam int RECV_QUIET_TO   = 1500;
	// Report count at which the receiver starts its long hold-off.
	localparam int HOLD_AT         = 300;
	localparam int HOLD_CYCLES     = 90;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	kind_t                 kind       = KIND_SAMPLE;
	sample_t               adc_sample = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  got_press;
	key_t                  pressed_button;
	logic                  cfg_we     = 1'b0;
	cfg_idx_t              cfg_index  = REG_LIMIT_LEFT;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	key_report_book book = new();

	int requests_sent   = 0;
	int samples_dropped = 0;
	int settings_used   = 1;
	int watch_cycles    = 0;

	analog_keypad_debouncer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.got_press      (got_press),
		.pressed_button (pressed_button),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run.
	initial begin
		while (watch_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			watch_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Report side: stall at random, hold off once for a long stretch, and
	// check every report taken. Stall is driven at the rising edge and the
	// outputs are read at the falling edge, so the handshake seen there is
	// the one the next rising edge completes.
	// ------------------------------------------------------------------------
	bit   took      = 1'b0;
	bit   hold_used = 1'b0;
	int   hold_left = 0;
	logic took_flag;
	key_t took_key;

	always begin
		@(posedge clk);
		if (took)
			book.check_result(took_flag, took_key);
		if (!hold_used && book.reports_checked >= HOLD_AT) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (book.reports_checked >= RECV_QUIET_FROM &&
				book.reports_checked < RECV_QUIET_TO) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 19);
		end
		@(negedge clk);
		took      = (out_valid === 1'b1) && (out_stall === 1'b0);
		took_flag = got_press;
		took_key  = pressed_button;
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offer one request after an optional random gap; hold it until taken and
	// then book it. counted is low for a sample the block drops.
	task automatic send_request(input kind_t k, input sample_t level, output bit counted);
		bit go;
		while (!(requests_sent >= SEND_QUIET_FROM && requests_sent < SEND_QUIET_TO) &&
				$urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		adc_sample <= level;
		do begin
			@(negedge clk);
			go = (in_stall === 1'b0);
			@(posedge clk);
		end while (!go);
		counted = book.note_request(k, level);
		if (!counted)
			samples_dropped++;
		requests_sent++;
	endtask

	// Drop valid and let every outstanding report come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (book.expected_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		book.write_reg(idx, data);
	endtask

	// Load a full register set while the block is idle.
	task automatic apply_settings(input cfg_t c, input bit poke_unused);
		drain();
		write_reg(REG_LIMIT_LEFT,      CFG_DATA_W'(c.limit_left));
		write_reg(REG_LIMIT_UP,        CFG_DATA_W'(c.limit_up));
		write_reg(REG_LIMIT_DOWN,      CFG_DATA_W'(c.limit_down));
		write_reg(REG_LIMIT_RIGHT,     CFG_DATA_W'(c.limit_right));
		write_reg(REG_LIMIT_CENTER,    CFG_DATA_W'(c.limit_center));
		write_reg(REG_DEBOUNCE_NEEDED, CFG_DATA_W'(c.debounce_needed));
		write_reg(REG_REPEAT_DELAY,    c.repeat_delay);
		// a write past the last register must change nothing
		if (poke_unused)
			write_reg(REG_UNUSED, 32'h0000_03FF);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic cfg_t make_cfg(int l, int u, int d, int r, int c, int deb,
			logic [31:0] dly);
		cfg_t s;
		s.limit_left      = sample_t'(l);
		s.limit_up        = sample_t'(u);
		s.limit_down      = sample_t'(d);
		s.limit_right     = sample_t'(r);
		s.limit_center    = sample_t'(c);
		s.debounce_needed = count_t'(deb);
		s.repeat_delay    = dly;
		return s;
	endfunction

	// Half the time a uniform level, else one just at or under a threshold.
	function automatic sample_t pick_level();
		int lvl;
		if ($urandom_range(0, 1))
			return sample_t'($urandom_range(0, 1023));
		case ($urandom_range(0, 4))
			0: lvl = int'(book.regs.limit_left);
			1: lvl = int'(book.regs.limit_up);
			2: lvl = int'(book.regs.limit_down);
			3: lvl = int'(book.regs.limit_right);
			default: lvl = int'(book.regs.limit_center);
		endcase
		lvl -= int'($urandom_range(0, 1));
		return sample_t'((lvl < 0) ? 0 : lvl);
	endfunction

	function automatic sample_t jitter(sample_t level);
		int lvl;
		lvl = int'(level) + int'($urandom_range(0, 6)) - 3;
		if (lvl < 0)
			lvl = 0;
		if (lvl > 1023)
			lvl = 1023;
		return sample_t'(lvl);
	endfunction

	// Mostly held-key bursts, often followed by a take and some ticks, the way a
	// real press is serviced; the rest is loose ticks, takes, clears and
	// stray samples. Every request sent counts toward goal.
	task automatic random_traffic(input int goal);
		int      done;
		int      pick;
		int      len;
		sample_t anchor;
		sample_t level;
		bit      c;
		done = 0;
		while (done < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				anchor = pick_level();
				len = $urandom_range(1, int'(book.regs.debounce_needed) + 4);
				repeat (len) begin
					level = ($urandom_range(0, 4) == 0) ? jitter(anchor) : anchor;
					send_request(KIND_SAMPLE, level, c);
					done++;
				end
				if ($urandom_range(0, 9) < 7) begin
					send_request(KIND_TAKE, sample_t'($urandom), c);
					done++;
				end
				if ($urandom_range(0, 1)) begin
					repeat ($urandom_range(1, 8)) begin
						send_request(KIND_TICK, sample_t'($urandom), c);
						done++;
					end
				end
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 6)) begin
					send_request(KIND_TICK, sample_t'($urandom), c);
					done++;
				end
			end else if (pick < 85) begin
				send_request(KIND_TAKE, sample_t'($urandom), c);
				done++;
			end else if (pick < 93) begin
				send_request(KIND_CLEAR, sample_t'($urandom), c);
				done++;
			end else begin
				send_request(KIND_SAMPLE, sample_t'($urandom_range(0, 1023)), c);
				done++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	int edges[10] = '{49, 50, 199, 200, 399, 400, 599, 600, 799, 800};

	initial begin
		bit c;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset thresholds (debounce 5, no lockout).
		// Take and tick with nothing pending and the lockout already at zero.
		send_request(KIND_TAKE, 10'h3FF, c);
		send_request(KIND_TICK, 10'h2AA, c);
		// no-key repeats count but never latch
		repeat (2) send_request(KIND_SAMPLE, 10'd1023, c);
		// left held long enough to pass the debounce count
		repeat (7) send_request(KIND_SAMPLE, 10'd0, c);
		// dropped while the press is pending
		send_request(KIND_SAMPLE, 10'd0, c);
		send_request(KIND_TAKE, 10'h000, c);
		// second take finds nothing but still shows the held key
		send_request(KIND_TAKE, 10'h155, c);
		send_request(KIND_CLEAR, 10'h155, c);
		// each side of every reset threshold
		foreach (edges[i])
			send_request(KIND_SAMPLE, sample_t'(edges[i]), c);

		random_traffic(250);

		// Evenly spaced bands, latch on the first repeat, short lockout.
		apply_settings(make_cfg(100, 300, 500, 700, 900, 0, 32'd3), 1'b0);
		random_traffic(300);

		// Out-of-order thresholds leave the up and right bands empty.
		apply_settings(make_cfg(600, 200, 700, 650, 1023, 2, 32'd0), 1'b1);
		random_traffic(250);

		// All thresholds at zero: every level decodes as no key.
		apply_settings(make_cfg(0, 0, 0, 0, 0, 0, 32'd7), 1'b0);
		random_traffic(150);

		// All thresholds at the top and the largest debounce count: the
		// repeat counter saturates and no press is ever latched.
		apply_settings(make_cfg(1023, 1023, 1023, 1023, 1023, 255, 32'd0), 1'b0);
		random_traffic(400);

		// Reset bands again with a long lockout that ticks must wear down.
		apply_settings(make_cfg(50, 200, 400, 600, 800, 10, 32'd20), 1'b0);
		random_traffic(350);

		// Largest lockout last: once a key latches, sampling stays blocked.
		apply_settings(make_cfg(50, 200, 400, 600, 800, 1, 32'hFFFF_FFFF), 1'b0);
		random_traffic(250);

		drain();
		repeat (8) @(posedge clk);

		if (book.expected_reports.size() != 0) begin
			$error("%0d reports never arrived", book.expected_reports.size());
			book.mismatches++;
		end
		$display("Run covered %0d requests (%0d samples ignored) under %0d register settings,",
			requests_sent, samples_dropped, settings_used);
		$display("%0d presses latched, %0d reports compared, %0d mismatches.",
			book.presses_latched, book.reports_checked, book.mismatches);
		if (book.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
